// ===== sv/two_way_traffic_light_timer_defines.svh =====
// assertion macros for the two-way traffic light timer
`ifndef TWO_WAY_TRAFFIC_LIGHT_TIMER_DEFINES_SVH
`define TWO_WAY_TRAFFIC_LIGHT_TIMER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define TWTL_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define TWTL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/twtl_pkg.sv =====
// shared types, constants and segment table of the traffic light timer
package twtl_pkg;

    localparam int POT_W     = 10;
    localparam int CFG_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int PHASE_W   = 2;
    localparam int SEG_W     = 8;
    localparam int DIGIT_W   = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    localparam int SAMPLE_BITS_DEF = 10;

    localparam logic [COUNT_W-1:0] DUR_MAX       = 7'd99;
    localparam logic [CFG_W-1:0]   FULL_TIME_RST = 7'd60;
    localparam logic [CFG_W-1:0]   WARN_RST      = 7'd2;
    localparam logic [COUNT_W-1:0] COUNT_A_RST   = 7'd60;
    localparam logic [COUNT_W-1:0] COUNT_B_RST   = 7'd45;

    // lamp codes as they appear on the phase outputs
    localparam logic [PHASE_W-1:0] PH_MAIN = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WARN = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ALT  = 2'd2;

    // register index taken from paddr bit 2
    localparam logic REG_FULL_TIME  = 1'b0;
    localparam logic REG_WARN_TICKS = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PHASE_W-1:0] phase;
    } head_t;

    // result item, phase_a in the lowest bits
    typedef struct packed {
        logic [SEG_W-1:0]   seg_b_ones;
        logic [SEG_W-1:0]   seg_b_tens;
        logic [SEG_W-1:0]   seg_a_ones;
        logic [SEG_W-1:0]   seg_a_tens;
        logic [COUNT_W-1:0] remain_b;
        logic [COUNT_W-1:0] remain_a;
        logic [PHASE_W-1:0] phase_b;
        logic [PHASE_W-1:0] phase_a;
    } result_t;

    // active-low segment code of one decimal digit, saturated at nine
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h40;
            4'd1:    code = 8'h79;
            4'd2:    code = 8'h24;
            4'd3:    code = 8'h30;
            4'd4:    code = 8'h19;
            4'd5:    code = 8'h12;
            4'd6:    code = 8'h02;
            4'd7:    code = 8'h78;
            4'd8:    code = 8'h00;
            default: code = 8'h10;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/twtl_head.sv =====
// next count and phase of one signal head, with its two digit codes
module twtl_head (
    input  twtl_pkg::head_t                   cur,
    input  logic [twtl_pkg::COUNT_W-1:0]      duration,
    input  logic [twtl_pkg::CFG_W-1:0]        warn_ticks,
    output twtl_pkg::head_t                   nxt,
    output logic [twtl_pkg::SEG_W-1:0]        seg_tens,
    output logic [twtl_pkg::SEG_W-1:0]        seg_ones
);
    import twtl_pkg::*;

    logic                 expire;
    logic [COUNT_W+1:0]   dur_x3;
    logic [COUNT_W-1:0]   reload;
    logic [COUNT_W-1:0]   count_new;
    logic [PHASE_W-1:0]   phase_new;
    logic [14:0]          tens_prod;
    logic [DIGIT_W-1:0]   tens;
    logic [DIGIT_W-1:0]   ones;

    // reload value and countdown
    always_comb
    begin
        expire = (cur.count <= 7'd1);
        dur_x3 = (COUNT_W+2)'(duration) + {1'b0, duration, 1'b0};
        if (cur.phase == PH_MAIN)
        begin
            reload = duration;
        end
        else
        begin
            reload = dur_x3[COUNT_W+1:2];
        end
        if (reload == '0)
        begin
            reload = 7'd1;
        end
        if (expire)
        begin
            count_new = reload;
            phase_new = (cur.phase == PH_MAIN) ? PH_ALT : PH_MAIN;
        end
        else
        begin
            count_new = cur.count - 7'd1;
            phase_new = cur.phase;
        end
        // late part of phase 2 shows as warning
        if (count_new <= warn_ticks && phase_new == PH_ALT)
        begin
            phase_new = PH_WARN;
        end
        nxt.count = count_new;
        nxt.phase = phase_new;
    end

    // decimal digits: divide by ten through the reciprocal 205 / 2048
    always_comb
    begin
        tens_prod = 15'(count_new) * 15'd205;
        tens      = tens_prod[14:11];
        ones      = DIGIT_W'(count_new - 7'(tens) * 7'd10);
        seg_tens  = seg_of(tens);
        seg_ones  = seg_of(ones);
    end

endmodule

// ===== sv/two_way_traffic_light_timer.sv =====
// two-way traffic light timer: one tick per item, result registered after acceptance
// throughput: one item per cycle while the skid entry is empty; a two-entry output buffer absorbs one stalled result
// s_tready drops only while both output entries are full
// reset (rst_n low, asynchronous): heads at 60 / 45 in phases 2 / 0, duration 0,
// full_time 60, warn_ticks 2, output buffer empty
`include "two_way_traffic_light_timer_defines.svh"

module two_way_traffic_light_timer #(
    parameter int SAMPLE_BITS = twtl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [twtl_pkg::IN_DATA_W-1:0]      s_tdata,   // [9:0] pot_sample
    // result item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] phase_a, [3:2] phase_b, [10:4] remain_a, [17:11] remain_b,
    // [25:18] seg_a_tens, [33:26] seg_a_ones, [41:34] seg_b_tens, [49:42] seg_b_ones
    output logic [twtl_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import twtl_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + CFG_W;
    localparam logic [SAMPLE_BITS:0] MAX_SAMPLE = (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - 1);

    logic [CFG_W-1:0]    full_time_reg;
    logic [CFG_W-1:0]    warn_ticks_reg;
    logic [COUNT_W-1:0]  dur_reg;
    logic [COUNT_W-1:0]  dur_next;
    head_t               head_a_reg;
    head_t               head_b_reg;
    head_t               head_a_next;
    head_t               head_b_next;

    result_t             out_data_reg;
    result_t             out_data_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             skid_data_reg;
    logic                skid_valid_reg;
    logic                skid_valid_next;

    result_t             res;
    logic                in_accept;
    logic                out_pop;
    logic                cfg_write;

    logic [SAMPLE_BITS-1:0] sample;
    logic [PROD_W-1:0]      prod;
    logic [COUNT_W-1:0]     quot0;
    logic [SAMPLE_BITS:0]   rem;
    logic [COUNT_W:0]       quot;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WARN_TICKS) ? 32'(warn_ticks_reg) : 32'(full_time_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_time_reg  <= FULL_TIME_RST;
            warn_ticks_reg <= WARN_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_FULL_TIME:  full_time_reg  <= pwdata[CFG_W-1:0];
                REG_WARN_TICKS: warn_ticks_reg <= pwdata[CFG_W-1:0];
                default:        full_time_reg  <= full_time_reg;
            endcase
        end
    end

    // handshake
    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign out_pop   = out_valid_reg && m_tready;
    assign m_tdata   = OUT_DATA_W'(out_data_reg);

    // per-head update
    twtl_head u_head_a (
        .cur        (head_a_reg),
        .duration   (dur_reg),
        .warn_ticks (warn_ticks_reg),
        .nxt        (head_a_next),
        .seg_tens   (res.seg_a_tens),
        .seg_ones   (res.seg_a_ones)
    );

    twtl_head u_head_b (
        .cur        (head_b_reg),
        .duration   (dur_reg),
        .warn_ticks (warn_ticks_reg),
        .nxt        (head_b_next),
        .seg_tens   (res.seg_b_tens),
        .seg_ones   (res.seg_b_ones)
    );

    assign res.phase_a  = head_a_next.phase;
    assign res.phase_b  = head_b_next.phase;
    assign res.remain_a = head_a_next.count;
    assign res.remain_b = head_b_next.count;

    // duration for the next tick: sample * full_time / (2^n - 1), quotient
    // estimate from the upper bits, then one compare corrects it
    always_comb
    begin
        sample = SAMPLE_BITS'(s_tdata[POT_W-1:0]);
        prod   = PROD_W'(sample) * PROD_W'(full_time_reg);
        quot0  = prod[PROD_W-1:SAMPLE_BITS];
        rem    = {1'b0, prod[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(quot0);
        quot   = {1'b0, quot0} + (COUNT_W+1)'(rem >= MAX_SAMPLE);
        if (quot > (COUNT_W+1)'(DUR_MAX))
        begin
            dur_next = DUR_MAX;
        end
        else
        begin
            dur_next = quot[COUNT_W-1:0];
        end
    end

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg    <= '0;
            head_a_reg <= '{count: COUNT_A_RST, phase: PH_ALT};
            head_b_reg <= '{count: COUNT_B_RST, phase: PH_MAIN};
        end
        else if (in_accept)
        begin
            dur_reg    <= dur_next;
            head_a_reg <= head_a_next;
            head_b_reg <= head_b_next;
        end
    end

    // output register plus skid entry
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_accept)
        begin
            skid_data_reg <= res;
        end
    end

    // checks
    `TWTL_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid entry without output entry")
    `TWTL_ASSERT_NEXT(a_stall_to_skid, in_accept && out_valid_reg && !m_tready, skid_valid_reg, "stalled item not kept in skid")
    `TWTL_ASSERT(a_dur_range, dur_reg <= DUR_MAX, "duration above 99")
    `TWTL_ASSERT(a_count_range, head_a_reg.count != '0 && head_b_reg.count != '0, "head count zero")

endmodule
